// ===== src/sharpen_3x3_line_filter_defines.svh =====
// Assertion macros shared by the sharpen filter checker.
`ifndef SHARPEN_3X3_LINE_FILTER_DEFINES_SVH
`define SHARPEN_3X3_LINE_FILTER_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted
`define SHP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sharpen filter: same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted
`define SHP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sharpen filter: next-cycle check failed");

`endif

// ===== src/shp_pkg.sv =====
// Shared types and constants for the 3x3 sharpen line filter.
`default_nettype none

package shp_pkg;

  localparam int PIX_W      = 8;
  localparam int WIDTH_W    = 13;
  localparam int MAX_WIDTH  = 4096;
  localparam int MIN_WIDTH  = 2;
  localparam int RST_WIDTH  = 640;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // One queued column command: which results to produce and the pixels they need
  typedef struct packed {
    logic             has_filt;
    logic             has_pass;
    logic             pass_end;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] down;
    logic [PIX_W-1:0] pass_pix;
  } shp_cmd_t;

  // Queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } shp_q_stat_t;

endpackage

`default_nettype wire

// ===== src/shp_front.sv =====
// Front part: takes columns, keeps the windows and column count, issues commands.
`default_nettype none

module shp_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [shp_pkg::WIDTH_W-1:0]   cfg_wdata,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [3*shp_pkg::PIX_W-1:0]   in_tdata,
  input  wire shp_pkg::shp_q_stat_t          q_stat,
  output logic                               push,
  output shp_pkg::shp_cmd_t                  push_cmd
);

  logic [shp_pkg::WIDTH_W-1:0] line_width_r;
  logic [shp_pkg::WIDTH_W-1:0] col_r, col_nxt;
  logic [shp_pkg::PIX_W-1:0]   above_r, below_r, ctr_prev1_r, ctr_prev2_r;
  logic [shp_pkg::WIDTH_W-1:0] width_eff;
  logic [shp_pkg::PIX_W-1:0]   up_in, mid_in, down_in;
  logic                        accept, is_last;

  assign up_in   = in_tdata[shp_pkg::PIX_W-1:0];
  assign mid_in  = in_tdata[2*shp_pkg::PIX_W-1:shp_pkg::PIX_W];
  assign down_in = in_tdata[3*shp_pkg::PIX_W-1:2*shp_pkg::PIX_W];

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  // Line width held within its legal range
  always_comb begin
    priority if (line_width_r < shp_pkg::WIDTH_W'(shp_pkg::MIN_WIDTH)) begin
      width_eff = shp_pkg::WIDTH_W'(shp_pkg::MIN_WIDTH);
    end else if (line_width_r > shp_pkg::WIDTH_W'(shp_pkg::MAX_WIDTH)) begin
      width_eff = shp_pkg::WIDTH_W'(shp_pkg::MAX_WIDTH);
    end else begin
      width_eff = line_width_r;
    end
  end

  // Last column: past the start and at or beyond width minus one
  assign is_last = (col_r != '0) && (col_r >= width_eff - shp_pkg::WIDTH_W'(1));
  assign col_nxt = is_last ? '0 : col_r + shp_pkg::WIDTH_W'(1);

  // Classify the column into a command
  always_comb begin
    push_cmd.has_filt = col_r >= shp_pkg::WIDTH_W'(2);
    push_cmd.has_pass = (col_r == '0) || is_last;
    push_cmd.pass_end = is_last;
    push_cmd.up       = above_r;
    push_cmd.left     = ctr_prev2_r;
    push_cmd.mid      = ctr_prev1_r;
    push_cmd.right    = mid_in;
    push_cmd.down     = below_r;
    push_cmd.pass_pix = mid_in;
  end

  assign push = accept && (push_cmd.has_filt || push_cmd.has_pass);

  // Control state: width register and column count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= shp_pkg::WIDTH_W'(shp_pkg::RST_WIDTH);
      col_r        <= '0;
    end else begin
      if (cfg_we) begin
        line_width_r <= cfg_wdata;
      end
      if (accept) begin
        col_r <= col_nxt;
      end
    end
  end

  // Window registers; reset to zero as the line start reads them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r     <= '0;
      below_r     <= '0;
      ctr_prev1_r <= '0;
      ctr_prev2_r <= '0;
    end else if (accept) begin
      above_r     <= up_in;
      below_r     <= down_in;
      ctr_prev2_r <= ctr_prev1_r;
      ctr_prev1_r <= mid_in;
    end
  end

endmodule

`default_nettype wire

// ===== src/shp_fifo.sv =====
// Short command queue between front and back parts.
`default_nettype none

module shp_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire shp_pkg::shp_cmd_t  push_cmd,
  input  wire logic               pop,
  output shp_pkg::shp_cmd_t       head_cmd,
  output shp_pkg::shp_q_stat_t    q_stat
);

  shp_pkg::shp_cmd_t             mem_r [shp_pkg::FIFO_DEPTH];
  logic [shp_pkg::PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [shp_pkg::CNT_W-1:0]     cnt_r;
  logic                          do_push, do_pop;

  assign q_stat.full  = cnt_r == shp_pkg::CNT_W'(shp_pkg::FIFO_DEPTH);
  assign q_stat.empty = cnt_r == '0;
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_cmd     = mem_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + shp_pkg::PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + shp_pkg::PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + shp_pkg::CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - shp_pkg::CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== src/shp_back.sv =====
// Back part: sharpen arithmetic and result sequencing into the output register.
`default_nettype none

module shp_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire shp_pkg::shp_cmd_t         head_cmd,
  input  wire shp_pkg::shp_q_stat_t      q_stat,
  output logic                           pop,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [shp_pkg::PIX_W-1:0]      out_tdata,
  output logic                           out_tlast,
  output logic                           out_tuser
);

  // Stage 1: partial sum per command
  logic                      s1_valid_r, s1_filt_r, s1_pass_r, s1_end_r;
  logic signed [10:0]        s1_t_r;
  logic [shp_pkg::PIX_W-1:0] s1_pix_r;
  // Output register
  logic                      out_valid_r, out_end_r, out_last_r;
  logic [shp_pkg::PIX_W-1:0] out_pix_r;

  logic signed [10:0]        t0, t1, t2;
  logic [19:0]               prod;
  logic [8:0]                quot;
  logic [shp_pkg::PIX_W-1:0] filt_pix;
  logic                      out_adv, emit, s1_done, s1_load;

  // 4*mid - neighbours, floor divide by 4, plus 3*up
  assign t0 = $signed({1'b0, head_cmd.mid, 2'b00})
            - $signed({3'b000, head_cmd.up})
            - $signed({3'b000, head_cmd.down})
            - $signed({3'b000, head_cmd.left})
            - $signed({3'b000, head_cmd.right});
  assign t1 = t0 >>> 2;
  assign t2 = t1 + $signed({2'b00, head_cmd.up, 1'b0}) + $signed({3'b000, head_cmd.up});

  // Divide by 3 via reciprocal 683/2048, exact for values below 2048; then clamp
  assign prod = 20'(s1_t_r[9:0]) * 20'd683;
  assign quot = prod[19:11];
  always_comb begin
    priority if (s1_t_r[10]) begin
      filt_pix = '0;
    end else if (quot > 9'd255) begin
      filt_pix = 8'hFF;
    end else begin
      filt_pix = quot[7:0];
    end
  end

  // Handshake between stages
  assign out_adv = !out_valid_r || out_tready;
  assign emit    = s1_valid_r && out_adv;
  assign s1_done = emit && !(s1_filt_r && s1_pass_r);
  assign s1_load = !q_stat.empty && (!s1_valid_r || s1_done);
  assign pop     = s1_load;

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_filt_r  <= 1'b0;
      s1_pass_r  <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
      s1_filt_r  <= head_cmd.has_filt;
      s1_pass_r  <= head_cmd.has_pass;
    end else if (s1_done) begin
      s1_valid_r <= 1'b0;
    end else if (emit) begin
      // two-result column: filtered pixel went out, pass-through remains
      s1_filt_r <= 1'b0;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_t_r   <= t2;
      s1_pix_r <= head_cmd.pass_pix;
      s1_end_r <= head_cmd.pass_end;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Output register payload: filtered pixel first, pass-through after
  always_ff @(posedge clk) begin
    if (emit) begin
      if (s1_filt_r) begin
        out_pix_r  <= filt_pix;
        out_end_r  <= 1'b0;
        out_last_r <= !s1_pass_r;
      end else begin
        out_pix_r  <= s1_pix_r;
        out_end_r  <= s1_end_r;
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_end_r;

endmodule

`default_nettype wire

// ===== src/sharpen_3x3_line_filter.sv =====
// Top level of the 3x3 sharpen line filter.
//
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready  in_tdata: above, centre, below pixel
//  out_     out  out_tvalid/out_tready out_tdata: pixel; tlast: run last; tuser: line end
//  cfg_     in   cfg_we               cfg_wdata: line width in pixels
//
// One column is taken per clock while the command queue has room; the last column of a
// line wider than two pixels yields two results, the filtered pixel and then the
// pass-through. A column's results pass the command queue, then the arithmetic stage
// register, which loads the output register.
// Reset is synchronous, active low; the line width returns to 640 pixels.
// A stalled output fills the four-entry command queue before in_tready drops.
`default_nettype none

module sharpen_3x3_line_filter (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [shp_pkg::WIDTH_W-1:0]  cfg_wdata,  // line_width
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [3*shp_pkg::PIX_W-1:0]  in_tdata,   // above_pixel, center_pixel, below_pixel
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [shp_pkg::PIX_W-1:0]         out_tdata,  // out_pixel
  output logic                              out_tlast,  // run_last
  output logic                              out_tuser   // line_end
);

  shp_pkg::shp_cmd_t    push_cmd, head_cmd;
  shp_pkg::shp_q_stat_t q_stat;
  logic                 push, pop;

  shp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  shp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  shp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_cmd   (head_cmd),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ===== src/shp_checker.sv =====
// Port-level checks for the sharpen line filter, bound to the top level.
`default_nettype none
`include "sharpen_3x3_line_filter_defines.svh"

module shp_checker (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         out_tvalid,
  input  wire logic                         out_tready,
  input  wire logic [shp_pkg::PIX_W-1:0]    out_tdata,
  input  wire logic                         out_tlast,
  input  wire logic                         out_tuser
);

  // a stalled result transaction keeps its contents
  `SHP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))

  // a line end is always the last result of its column
  `SHP_ASSERT_NOW(a_end_is_last, out_tvalid && out_tuser, out_tlast)

  // the pass-through pixel follows the filtered one straight away
  `SHP_ASSERT_NEXT(a_pair_back_to_back, out_tvalid && out_tready && !out_tlast, out_tvalid && out_tlast && out_tuser)

endmodule

bind sharpen_3x3_line_filter shp_checker u_shp_checker (.*);

`default_nettype wire

// ===== sim/sharpen_3x3_line_filter_test.sv =====
// Self-checking testbench for the 3x3 sharpen line filter: directed and random columns.
`timescale 1ns / 100ps

module sharpen_3x3_line_filter_test;

  localparam int PIX_W     = shp_pkg::PIX_W;
  localparam int WIDTH_W   = shp_pkg::WIDTH_W;
  localparam int MAX_WIDTH = shp_pkg::MAX_WIDTH;
  localparam int MIN_WIDTH = shp_pkg::MIN_WIDTH;
  localparam int RST_WIDTH = shp_pkg::RST_WIDTH;

  localparam int RANDOM_COLUMNS = 950;
  localparam int SETTLE_CYCLES  = 8;
  localparam int CYCLE_LIMIT    = 1000000;

  // One expected output pixel with its sideband bits
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             line_end;
    logic             run_last;
  } filtered_pixel_t;

  // Line filter predictor plus the queue of pixels still to come out
  class sharpen_scoreboard;
    logic [WIDTH_W-1:0] width_reg;
    logic [PIX_W-1:0]   up_win[2];
    logic [PIX_W-1:0]   mid_win[2];
    logic [PIX_W-1:0]   down_win[2];
    int                 col;
    filtered_pixel_t    pending_pixels[$];
    int                 n_columns;
    int                 n_results;
    int                 n_lines;
    int                 n_errors;

    function new();
      width_reg = WIDTH_W'(RST_WIDTH);
      for (int k = 0; k < 2; k++) begin
        up_win[k]   = '0;
        mid_win[k]  = '0;
        down_win[k] = '0;
      end
      col       = 0;
      n_columns = 0;
      n_results = 0;
      n_lines   = 0;
      n_errors  = 0;
    endfunction

    function void set_width(logic [WIDTH_W-1:0] w);
      width_reg = w;
    endfunction

    // Width as the block uses it, clamped to the supported range
    function int line_len();
      int w;
      w = int'(width_reg);
      if (w < MIN_WIDTH) w = MIN_WIDTH;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
    endfunction

    function int pending_count();
      return pending_pixels.size();
    endfunction

    function logic [PIX_W-1:0] sharpen_pixel(int up, int left, int centre, int right, int down);
      int acc;
      acc = 4 * centre - up - down - left - right;
      acc = acc >>> 2;          // floor division by four
      acc = acc + 3 * up;
      acc = acc / 3;            // truncates toward zero
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      return acc[PIX_W-1:0];
    endfunction

    function void push_pixel(logic [PIX_W-1:0] pix, logic line_end, logic run_last);
      filtered_pixel_t r;
      r.pixel    = pix;
      r.line_end = line_end;
      r.run_last = run_last;
      pending_pixels.push_back(r);
    endfunction

    // Accepted input transaction: one column of above, centre and below pixels
    function void note_column(logic [3*PIX_W-1:0] d);
      logic [PIX_W-1:0] up;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] down;
      bit               last_col;
      up       = d[PIX_W-1:0];
      mid      = d[2*PIX_W-1:PIX_W];
      down     = d[3*PIX_W-1:2*PIX_W];
      last_col = (col >= 1) && (col >= line_len() - 1);
      if (col == 0) begin
        push_pixel(mid, 1'b0, 1'b1);
      end else begin
        if (col >= 2)
          push_pixel(sharpen_pixel(int'(up_win[1]), int'(mid_win[0]), int'(mid_win[1]),
                                   int'(mid), int'(down_win[1])),
                     1'b0, !last_col);
        if (last_col) push_pixel(mid, 1'b1, 1'b1);
      end
      up_win[0]   = up_win[1];
      up_win[1]   = up;
      mid_win[0]  = mid_win[1];
      mid_win[1]  = mid;
      down_win[0] = down_win[1];
      down_win[1] = down;
      col = last_col ? 0 : col + 1;
      n_columns++;
    endfunction

    // Accepted output transaction against the oldest expectation
    function void check_result(logic [PIX_W-1:0] pix, logic line_end, logic run_last);
      filtered_pixel_t r;
      n_results++;
      if (line_end) n_lines++;
      if (pending_pixels.size() == 0) begin
        $error("unexpected output pixel %0d (line_end %0b, run_last %0b)",
               pix, line_end, run_last);
        n_errors++;
        return;
      end
      r = pending_pixels.pop_front();
      if (pix !== r.pixel) begin
        $error("out_pixel mismatch: expected %0d, got %0d", r.pixel, pix);
        n_errors++;
      end
      if (line_end !== r.line_end) begin
        $error("line_end mismatch: expected %0b, got %0b", r.line_end, line_end);
        n_errors++;
      end
      if (run_last !== r.run_last) begin
        $error("run_last mismatch: expected %0b, got %0b", r.run_last, run_last);
        n_errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [WIDTH_W-1:0]   cfg_wdata  = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [3*PIX_W-1:0]   in_tdata   = '0;    // above_pixel, center_pixel, below_pixel
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [PIX_W-1:0]     out_tdata;          // out_pixel
  logic                 out_tlast;          // run_last
  logic                 out_tuser;          // line_end

  sharpen_scoreboard sb = new();
  bit                quiet = 1'b0;          // no idling on either side while set
  int                stall_left = 0;
  int                cycle_count = 0;

  sharpen_3x3_line_filter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels outstanding",
               cycle_count, sb.pending_count());
      $display("FAILURE");
      $finish;
    end
  end

  // Sample all transactions at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
      if (cfg_we) sb.set_width(cfg_wdata);
      if (in_tvalid && in_tready) sb.note_column(in_tdata);
    end
  end

  // Receiver back-pressure in short bursts
  always @(negedge clk) begin
    if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 4);
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [PIX_W-1:0] rand_pix();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Drive one column; starts and ends at a falling edge
  task automatic send_col(input logic [PIX_W-1:0] up, input logic [PIX_W-1:0] mid,
                          input logic [PIX_W-1:0] down);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {down, mid, up};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_cols(input int n);
    repeat (n) send_col(rand_pix(), rand_pix(), rand_pix());
  endtask

  // Hold the sender until every expected pixel is out and the pipeline is empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_width(input int w);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= w[WIDTH_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic int pick_width();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(0, 3);
    if (r <= 13) return $urandom_range(2, 12);
    if (r <= 18) return $urandom_range(13, 80);
    return $urandom_range(81, 300);
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset width: line start, then a width cut mid-line ends the line at once
    send_col(8'd0, 8'd0, 8'd0);
    send_col(8'd255, 8'd255, 8'd255);
    send_col(8'd0, 8'd255, 8'd0);
    send_col(8'd255, 8'd0, 8'd255);
    send_col(8'd128, 8'd1, 8'd127);
    send_col(8'd1, 8'd254, 8'd0);
    write_width(3);
    send_col(8'd17, 8'd200, 8'd33);
    send_random_cols(3);

    // Out-of-range widths act as two; two-pixel lines
    write_width(0);
    send_random_cols(2);
    write_width(1);
    send_col(8'd255, 8'd0, 8'd255);
    send_col(8'd0, 8'd255, 8'd0);
    write_width(2);
    send_random_cols(2);

    // Clamp to 255, clamp to 0, then clamp to 255 again on the line's last column
    write_width(5);
    send_col(8'd0, 8'd0, 8'd0);
    send_col(8'd255, 8'd255, 8'd0);
    send_col(8'd0, 8'd0, 8'd255);
    send_col(8'd200, 8'd255, 8'd100);
    send_col(8'd255, 8'd0, 8'd255);

    // Random lines, with the odd broken line cut short by a width change
    while (sb.n_columns < RANDOM_COLUMNS) begin
      quiet = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 3) == 0) write_width(pick_width());
      if ($urandom_range(0, 7) == 0)
        send_random_cols($urandom_range(1, sb.line_len()));
      else
        send_random_cols(sb.line_len());
    end

    // Final stretch without idling: short lines, then the widest register value
    quiet = 1'b1;
    write_width(7);
    send_random_cols(14);
    write_width(8191);
    send_random_cols(150);

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d columns and %0d output pixels over %0d lines.",
             sb.n_columns, sb.n_results, sb.n_lines);
    $display("Widths from below the minimum up to the 13-bit maximum, mid-line width cuts,");
    $display("random idling on both sides and a %0d-cycle run; %0d mismatches.",
             cycle_count, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
